FILE: src/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg
// Shared types, widths and digit helpers for the radix digit string converter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

   localparam int VALUE_BITS = 32;
   localparam int BASE_W     = 5;
   localparam int CHAR_W     = 7;
   localparam int DIGIT_W    = 4;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int IDX_W      = $clog2(VALUE_BITS);

   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
   localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

   localparam logic [CHAR_W-1:0]  CHAR_MINUS  = CHAR_W'(45);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(65);
   localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = DIGIT_W'(10);

   // one classified item: sign, magnitude and clamped radix
   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
      logic [BASE_W-1:0]     base;
   } entry_type;

   // floor(2^VALUE_BITS / b); the quotient estimate is at most one low
   function automatic logic [VALUE_BITS-1:0] recip(input logic [BASE_W-1:0] b);
      logic [VALUE_BITS-1:0] r;
      begin
         case (b)
            5'd2:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 2);
            5'd3:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 3);
            5'd4:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 4);
            5'd5:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 5);
            5'd6:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 6);
            5'd7:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 7);
            5'd8:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 8);
            5'd9:    r = VALUE_BITS'((65'd1 << VALUE_BITS) / 9);
            5'd10:   r = VALUE_BITS'((65'd1 << VALUE_BITS) / 10);
            5'd11:   r = VALUE_BITS'((65'd1 << VALUE_BITS) / 11);
            5'd12:   r = VALUE_BITS'((65'd1 << VALUE_BITS) / 12);
            5'd13:   r = VALUE_BITS'((65'd1 << VALUE_BITS) / 13);
            5'd14:   r = VALUE_BITS'((65'd1 << VALUE_BITS) / 14);
            5'd15:   r = VALUE_BITS'((65'd1 << VALUE_BITS) / 15);
            default: r = VALUE_BITS'((65'd1 << VALUE_BITS) / 16);
         endcase
         return r;
      end
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      begin
         if (d < DIGIT_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
         end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_LIMIT);
         end
         return c;
      end
   endfunction

endpackage

FILE: src/rdsc_front.sv
// ----------------------------------------------------------------------------
// rdsc_front
// Holds the radix register and turns each request beat into sign, magnitude
// and clamped radix for the work queue.
// ----------------------------------------------------------------------------
module rdsc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [rdsc_pkg::BASE_W-1:0]          csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rdsc_pkg::VALUE_BITS-1:0] req_value,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output rdsc_pkg::entry_type                  push_data
);

   logic [rdsc_pkg::BASE_W-1:0]     base_ff;
   logic [rdsc_pkg::BASE_W-1:0]     base_eff;
   logic [rdsc_pkg::VALUE_BITS-1:0] raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= rdsc_pkg::BASE_RESET;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (base_ff < rdsc_pkg::BASE_MIN) begin
         base_eff = rdsc_pkg::BASE_MIN;
      end else if (base_ff > rdsc_pkg::BASE_MAX) begin
         base_eff = rdsc_pkg::BASE_MAX;
      end else begin
         base_eff = base_ff;
      end
   end

   assign raw              = req_value;
   assign push_data.neg    = raw[rdsc_pkg::VALUE_BITS-1];
   assign push_data.mag    = raw[rdsc_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;
   assign push_data.base   = base_eff;
   assign push_valid       = req_valid;
   assign req_ready        = push_ready;

endmodule

FILE: src/rdsc_queue.sv
// ----------------------------------------------------------------------------
// rdsc_queue
// Two-entry queue between the classifier and the conversion engine.
// ----------------------------------------------------------------------------
module rdsc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  rdsc_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output rdsc_pkg::entry_type pop_data
);

   rdsc_pkg::entry_type slot_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: src/rdsc_back.sv
// ----------------------------------------------------------------------------
// rdsc_back
// Conversion engine: repeated division by the radix through a reciprocal
// multiply and one correction step, digits kept in a stack, then emitted
// most significant first behind an output register.
// ----------------------------------------------------------------------------
module rdsc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  rdsc_pkg::entry_type               pop_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rdsc_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                              rsp_last
);

   localparam int VB = rdsc_pkg::VALUE_BITS;
   localparam int PW = 2 * VB;
   localparam int QW = VB + rdsc_pkg::BASE_W;

   typedef enum logic [1:0] {IDLE, MUL, FIX, EMIT} state_type;

   state_type                        state_ff, state_in;
   logic [VB-1:0]                    mag_ff, mag_in;
   logic [VB-1:0]                    q0_ff, q0_in;
   logic [rdsc_pkg::BASE_W-1:0]      base_ff, base_in;
   logic                             neg_ff, neg_in;
   logic [rdsc_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [rdsc_pkg::DIGIT_W-1:0]     dig_ff [VB];
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rdsc_pkg::CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [PW-1:0]                    prod;
   logic [QW-1:0]                    qb;
   logic [VB-1:0]                    rem;
   logic [VB-1:0]                    rem_fix;
   logic                             over;
   logic [rdsc_pkg::DIGIT_W-1:0]     digit;
   logic [VB-1:0]                    quot;
   logic [rdsc_pkg::CNT_W-1:0]       cnt_m1;
   logic [rdsc_pkg::IDX_W-1:0]       wr_idx;
   logic [rdsc_pkg::IDX_W-1:0]       rd_idx;
   logic                             out_free;
   logic                             dig_we;

   assign prod    = PW'(mag_ff) * PW'(rdsc_pkg::recip(base_ff));
   assign qb      = QW'(q0_ff) * QW'(base_ff);
   assign rem     = mag_ff - qb[VB-1:0];
   assign over    = (rem >= VB'(base_ff));
   assign rem_fix = rem - VB'(base_ff);
   assign digit   = over ? rem_fix[rdsc_pkg::DIGIT_W-1:0] : rem[rdsc_pkg::DIGIT_W-1:0];
   assign quot    = over ? (q0_ff + VB'(1)) : q0_ff;
   assign cnt_m1  = cnt_ff - rdsc_pkg::CNT_W'(1);
   assign wr_idx  = cnt_ff[rdsc_pkg::IDX_W-1:0];
   assign rd_idx  = cnt_m1[rdsc_pkg::IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign pop_ready     = (state_ff == IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      q0_in        = q0_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dig_we       = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (pop_valid) begin
               mag_in   = pop_data.mag;
               neg_in   = pop_data.neg;
               base_in  = pop_data.base;
               cnt_in   = '0;
               state_in = MUL;
            end
         end
         MUL: begin
            q0_in    = prod[PW-1:VB];
            state_in = FIX;
         end
         FIX: begin
            dig_we   = 1'b1;
            cnt_in   = cnt_ff + rdsc_pkg::CNT_W'(1);
            mag_in   = quot;
            state_in = (quot == '0) ? EMIT : MUL;
         end
         EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = rdsc_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = rdsc_pkg::digit_char(dig_ff[rd_idx]);
                  rsp_last_in = (cnt_m1 == '0);
                  cnt_in      = cnt_m1;
                  if (cnt_m1 == '0) begin
                     state_in = IDLE;
                  end
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      q0_ff       <= q0_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (dig_we) begin
         dig_ff[wr_idx] <= digit;
      end
   end

endmodule

FILE: src/radix_digit_string_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_string_converter
// Converts a signed 32-bit integer to ASCII text in radix 2 to 16.
// ----------------------------------------------------------------------------
// Usage:
//   csr_wr_en/csr_wr_data write the radix (reset 10); 0 and 1 act as 2,
//   17 to 31 act as 16. Write only while the block is idle.
//   req_valid/req_ready/req_value take one integer per beat.
//   rsp_valid/rsp_ready/rsp_char_code/rsp_last return one ASCII character
//   per beat, most significant digit first, '-' ahead of negative values,
//   rsp_last on the final character.
// Flow:
//   A front stage classifies each beat into a two-entry queue; the engine
//   finds each digit by a reciprocal multiply, then a remainder
//   correction, then emits one character per cycle while the receiver is
//   ready. The queue lets new requests land while the engine works; the
//   engine takes a new value only from its idle state.
// Reset clears the queue, the engine and the output register. A stalled
// receiver holds the current character; the engine waits, and the queue
// fills, after which req_ready drops.
// ----------------------------------------------------------------------------
module radix_digit_string_converter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [rdsc_pkg::BASE_W-1:0]            csr_wr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rdsc_pkg::VALUE_BITS-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [rdsc_pkg::CHAR_W-1:0]            rsp_char_code,
   output logic                                   rsp_last
);

   logic                push_valid;
   logic                push_ready;
   rdsc_pkg::entry_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   rdsc_pkg::entry_type pop_data;

   rdsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   rdsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rdsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule
